// ===== rtl/core/csv_record_parse_and_hash_top_defines.svh =====
// assertion macros for the csv record parser
`ifndef CSV_RECORD_PARSE_AND_HASH_TOP_DEFINES_SVH
`define CSV_RECORD_PARSE_AND_HASH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CSVRPH_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("csv record parser check failed");
`define CSVRPH_ASSERT_ALWAYS(label, clk_s, prop) \
    label: assert property (@(posedge clk_s) prop) \
        else $error("csv record parser reset check failed");
`else
`define CSVRPH_ASSERT(label, clk_s, rst_s, prop)
`define CSVRPH_ASSERT_ALWAYS(label, clk_s, prop)
`endif

`endif

// ===== rtl/core/csvrph_pkg.sv =====
// package with types, character codes and helpers for the csv record parser
package csvrph_pkg;

    localparam int BUCKET_COUNT_DEFAULT = 400;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [30:0] SAT31 = '1;

    typedef enum logic [3:0] {
        PH_START,
        PH_RANK,
        PH_OPEN_NAME,
        PH_NAME,
        PH_AFTER_NAME,
        PH_POP_KIND,
        PH_POP,
        PH_ACCEPT,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [30:0] rank;
        logic [30:0] population;
        logic [8:0]  hash_length;
        logic [8:0]  hash_sum;
        logic [8:0]  hash_product;
    } out_word_t;

    // acc * 10 + digit, saturating at 31 bits
    function automatic logic [30:0] dec_push(input logic [30:0] acc, input logic [3:0] digit);
        logic [34:0] wide;
        wide = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(digit);
        return (wide > 35'(SAT31)) ? SAT31 : wide[30:0];
    endfunction

endpackage

// ===== rtl/core/csvrph_if.sv =====
// valid/ready channel carrying one word of a given type
interface csvrph_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/csv_record_parse_and_hash_top.sv =====
// csv record parser with saturating decimal fields and name hashes
//
// text carries one byte of a line per word, line_end flags the last byte
// of the line. record carries one word per line: status, rank, population
// and the three name hashes (length, byte sum, product of the first two
// bytes, each modulo BUCKET_COUNT and cut to 9 bits); a malformed line
// gives status 1 with all other fields zero.
// throughput: one text word per cycle while no line end waits on a
// stalled record, set by the single parse stage that sits between the
// input register and the record register, which a line-end word loads.
// the name product is reduced in a three-register chain (multiply,
// reciprocal quotient, remainder) that runs beside the parser; a line always
// has at least three bytes after the second name byte, so it has settled.
// reset clears the valid flags of both registers and the parse state; the
// block then waits for the first byte of a line.
// when record is stalled, bytes keep flowing until the next line end, whose
// word stays in the input register and holds text.ready low.
`include "csv_record_parse_and_hash_top_defines.svh"

module csv_record_parse_and_hash_top #(
    parameter int BUCKET_COUNT = csvrph_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    csvrph_if.sink   text,
    csvrph_if.source record
);

    localparam int HW = $clog2(BUCKET_COUNT);
    localparam int XW = (HW > 9) ? HW : 9;
    localparam longint unsigned RECIP_L = (64'd1 << 32) / BUCKET_COUNT;
    localparam logic [31:0] RECIP = RECIP_L[31:0];
    localparam logic [16:0] BMUL = 17'(BUCKET_COUNT);

    // input register
    logic                 s0_valid_reg;
    csvrph_pkg::in_word_t s0_word_reg;
    logic                 s0_fire;

    // parse state
    csvrph_pkg::phase_t phase_reg, phase_next;
    logic [30:0]        rank_reg, rank_next;
    logic [30:0]        pop_reg, pop_next;
    logic [HW-1:0]      len_reg, len_next;
    logic [HW-1:0]      sum_reg, sum_next;
    logic [7:0]         first_reg, first_next;
    logic [1:0]         seen_reg, seen_next;
    logic               prod_load;

    // product reduction chain
    logic [15:0] prod_reg;
    logic [15:0] quo_reg;
    logic [HW:0] rem_reg;
    logic [47:0] quo_full;
    logic [16:0] quo_times_b;
    logic [HW-1:0] prod_mod;

    // record register
    logic                  out_valid_reg;
    csvrph_pkg::out_word_t out_word_reg;
    csvrph_pkg::out_word_t result;

    logic [7:0]    b;
    logic          is_dec;
    logic [3:0]    digit;
    logic [HW:0]   sum_wide;
    logic [HW-1:0] byte_mod_tbl [256];
    logic [HW-1:0] prod_hash;

    for (genvar i = 0; i < 256; i++) begin : g_byte_mod
        localparam int unsigned MODV = i % BUCKET_COUNT;
        assign byte_mod_tbl[i] = HW'(MODV);
    end

    function automatic logic [8:0] to9(input logic [HW-1:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        return e[8:0];
    endfunction

    assign b      = s0_word_reg.in_byte;
    assign is_dec = (b >= csvrph_pkg::CH_ZERO) && (b <= csvrph_pkg::CH_NINE);
    assign digit  = 4'(b - csvrph_pkg::CH_ZERO);

    assign s0_fire    = s0_valid_reg && (!s0_word_reg.line_end || !out_valid_reg || record.ready);
    assign text.ready = !s0_valid_reg || s0_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_fire)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s0_word_reg <= text.data;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = csvrph_pkg::PH_ERROR;
        unique case (phase_reg)
            csvrph_pkg::PH_START:
            begin
                phase_next = is_dec ? csvrph_pkg::PH_RANK : csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_RANK:
            begin
                if (is_dec)
                    phase_next = csvrph_pkg::PH_RANK;
                else if (b == csvrph_pkg::CH_COMMA)
                    phase_next = csvrph_pkg::PH_OPEN_NAME;
                else
                    phase_next = csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_OPEN_NAME:
            begin
                phase_next = (b == csvrph_pkg::CH_QUOTE) ? csvrph_pkg::PH_NAME
                                                         : csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_NAME:
            begin
                phase_next = (b == csvrph_pkg::CH_QUOTE) ? csvrph_pkg::PH_AFTER_NAME
                                                         : csvrph_pkg::PH_NAME;
            end
            csvrph_pkg::PH_AFTER_NAME:
            begin
                phase_next = (b == csvrph_pkg::CH_COMMA) ? csvrph_pkg::PH_POP_KIND
                                                         : csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_POP_KIND:
            begin
                if (b == csvrph_pkg::CH_QUOTE)
                    phase_next = csvrph_pkg::PH_POP;
                else if (b == csvrph_pkg::CH_LPAREN)
                    phase_next = csvrph_pkg::PH_ACCEPT;
                else
                    phase_next = csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_POP:
            begin
                if (is_dec || b == csvrph_pkg::CH_COMMA)
                    phase_next = csvrph_pkg::PH_POP;
                else if (b == csvrph_pkg::CH_QUOTE)
                    phase_next = csvrph_pkg::PH_ACCEPT;
                else
                    phase_next = csvrph_pkg::PH_ERROR;
            end
            csvrph_pkg::PH_ACCEPT:
            begin
                phase_next = csvrph_pkg::PH_ACCEPT;
            end
            default:
            begin
                phase_next = csvrph_pkg::PH_ERROR;
            end
        endcase
    end

    // accumulator and hash updates
    always_comb
    begin
        rank_next  = rank_reg;
        pop_next   = pop_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        prod_load  = 1'b0;
        sum_wide   = {1'b0, sum_reg} + {1'b0, byte_mod_tbl[b]};
        unique case (phase_reg)
            csvrph_pkg::PH_START,
            csvrph_pkg::PH_RANK:
            begin
                if (is_dec)
                    rank_next = csvrph_pkg::dec_push(rank_reg, digit);
            end
            csvrph_pkg::PH_NAME:
            begin
                if (b != csvrph_pkg::CH_QUOTE)
                begin
                    len_next = (len_reg == HW'(BUCKET_COUNT - 1)) ? '0 : len_reg + 1'b1;
                    sum_next = (sum_wide >= (HW + 1)'(BUCKET_COUNT))
                             ? HW'(sum_wide - (HW + 1)'(BUCKET_COUNT))
                             : sum_wide[HW-1:0];
                    if (seen_reg == 2'd0)
                        first_next = b;
                    prod_load = (seen_reg == 2'd1);
                    if (seen_reg != 2'd2)
                        seen_next = seen_reg + 2'd1;
                end
            end
            csvrph_pkg::PH_POP:
            begin
                if (is_dec)
                    pop_next = csvrph_pkg::dec_push(pop_reg, digit);
            end
            default:
            begin
                rank_next = rank_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= csvrph_pkg::PH_START;
            rank_reg  <= '0;
            pop_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            seen_reg  <= '0;
        end
        else if (s0_fire)
        begin
            if (s0_word_reg.line_end)
            begin
                phase_reg <= csvrph_pkg::PH_START;
                rank_reg  <= '0;
                pop_reg   <= '0;
                len_reg   <= '0;
                sum_reg   <= '0;
                first_reg <= '0;
                seen_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                rank_reg  <= rank_next;
                pop_reg   <= pop_next;
                len_reg   <= len_next;
                sum_reg   <= sum_next;
                first_reg <= first_next;
                seen_reg  <= seen_next;
            end
        end
    end

    // product modulo bucket count via reciprocal, quotient may be one low
    assign quo_full    = prod_reg * RECIP;
    assign quo_times_b = 17'(quo_reg * BMUL);
    assign prod_mod    = (rem_reg >= (HW + 1)'(BUCKET_COUNT))
                       ? HW'(rem_reg - (HW + 1)'(BUCKET_COUNT))
                       : rem_reg[HW-1:0];

    always_ff @(posedge clk)
    begin
        if (s0_fire && prod_load)
        begin
            prod_reg <= 16'(first_reg) * 16'(b);
        end
        quo_reg <= quo_full[47:32];
        rem_reg <= (HW + 1)'({1'b0, prod_reg} - quo_times_b);
    end

    always_comb
    begin
        priority if (seen_reg == 2'd2)
            prod_hash = prod_mod;
        else if (seen_reg == 2'd1)
            prod_hash = byte_mod_tbl[first_reg];
        else
            prod_hash = '0;
    end

    always_comb
    begin
        result = '0;
        if (phase_next == csvrph_pkg::PH_ACCEPT)
        begin
            result.status       = 1'b0;
            result.rank         = rank_reg;
            result.population   = pop_reg;
            result.hash_length  = to9(len_reg);
            result.hash_sum     = to9(sum_reg);
            result.hash_product = to9(prod_hash);
        end
        else
        begin
            result.status = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_fire && s0_word_reg.line_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (record.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_fire && s0_word_reg.line_end)
        begin
            out_word_reg <= result;
        end
    end

    assign record.valid = out_valid_reg;
    assign record.data  = out_word_reg;

    `CSVRPH_ASSERT(a_error_word_zero, clk, rst_n,
        out_valid_reg && out_word_reg.status |-> out_word_reg.rank == '0 &&
        out_word_reg.population == '0 && out_word_reg.hash_length == '0 &&
        out_word_reg.hash_sum == '0 && out_word_reg.hash_product == '0)
    `CSVRPH_ASSERT(a_line_end_restarts, clk, rst_n,
        s0_fire && s0_word_reg.line_end |=>
        phase_reg == csvrph_pkg::PH_START && seen_reg == 2'd0)
    `CSVRPH_ASSERT(a_hash_in_range, clk, rst_n,
        {1'b0, len_reg} < (HW + 1)'(BUCKET_COUNT) &&
        {1'b0, sum_reg} < (HW + 1)'(BUCKET_COUNT))
    `CSVRPH_ASSERT(a_stall_holds_line_end, clk, rst_n,
        s0_valid_reg && s0_word_reg.line_end && out_valid_reg && !record.ready |=>
        s0_valid_reg && $stable(phase_reg))
    `CSVRPH_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid_reg && !s0_valid_reg)

endmodule

// ===== tb/tb_top.sv =====
// testbench for the csv record parser: line stimulus, record prediction and checking
module tb_top;

    localparam int BUCKETS = csvrph_pkg::BUCKET_COUNT_DEFAULT;
    localparam int RANDOM_WORDS = 180;

    logic clk;
    logic rst_n;

    csvrph_if #(.word_t(csvrph_pkg::in_word_t))  text_if ();
    csvrph_if #(.word_t(csvrph_pkg::out_word_t)) record_if ();

    csv_record_parse_and_hash_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .record (record_if)
    );

    csvrph_pkg::phase_t line_phase;
    logic [30:0] rank_acc;
    logic [30:0] pop_acc;
    logic [8:0]  name_len;
    logic [8:0]  name_sum;
    logic [7:0]  first_b;
    logic [7:0]  second_b;
    logic [1:0]  name_seen;

    csvrph_pkg::out_word_t pending_records[$];
    logic [7:0]  line_bytes[$];
    int          error_count = 0;
    int          random_words = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;

    always #4 clk = ~clk;

    function automatic logic [30:0] shift_decimal(input logic [30:0] acc, input logic [7:0] b);
        logic [63:0] v;
        v = 64'(acc) * 64'd10 + 64'(b - csvrph_pkg::CH_ZERO);
        return (v > 64'(csvrph_pkg::SAT31)) ? csvrph_pkg::SAT31 : v[30:0];
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= csvrph_pkg::CH_ZERO && b <= csvrph_pkg::CH_NINE;
    endfunction

    function automatic logic [7:0] rand_digit();
        return csvrph_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic clear_line_state();
        line_phase = csvrph_pkg::PH_START;
        rank_acc   = '0;
        pop_acc    = '0;
        name_len   = '0;
        name_sum   = '0;
        first_b    = '0;
        second_b   = '0;
        name_seen  = '0;
    endtask

    task automatic parse_text_byte(input logic [7:0] b, input logic last);
        csvrph_pkg::out_word_t rec;
        case (line_phase)
            csvrph_pkg::PH_START:
                if (is_digit(b))
                begin
                    rank_acc   = shift_decimal(rank_acc, b);
                    line_phase = csvrph_pkg::PH_RANK;
                end
                else
                    line_phase = csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_RANK:
                if (is_digit(b))
                    rank_acc = shift_decimal(rank_acc, b);
                else if (b == csvrph_pkg::CH_COMMA)
                    line_phase = csvrph_pkg::PH_OPEN_NAME;
                else
                    line_phase = csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_OPEN_NAME:
                line_phase = (b == csvrph_pkg::CH_QUOTE) ? csvrph_pkg::PH_NAME
                                                         : csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_NAME:
                if (b == csvrph_pkg::CH_QUOTE)
                    line_phase = csvrph_pkg::PH_AFTER_NAME;
                else
                begin
                    name_len = 9'((int'(name_len) + 1) % BUCKETS);
                    name_sum = 9'((int'(name_sum) + int'(b)) % BUCKETS);
                    if (name_seen == 2'd0)
                        first_b = b;
                    else if (name_seen == 2'd1)
                        second_b = b;
                    if (name_seen < 2'd2)
                        name_seen = name_seen + 2'd1;
                end
            csvrph_pkg::PH_AFTER_NAME:
                line_phase = (b == csvrph_pkg::CH_COMMA) ? csvrph_pkg::PH_POP_KIND
                                                         : csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_POP_KIND:
                if (b == csvrph_pkg::CH_QUOTE)
                    line_phase = csvrph_pkg::PH_POP;
                else if (b == csvrph_pkg::CH_LPAREN)
                begin
                    pop_acc    = '0;
                    line_phase = csvrph_pkg::PH_ACCEPT;
                end
                else
                    line_phase = csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_POP:
                if (is_digit(b))
                    pop_acc = shift_decimal(pop_acc, b);
                else if (b == csvrph_pkg::CH_QUOTE)
                    line_phase = csvrph_pkg::PH_ACCEPT;
                else if (b != csvrph_pkg::CH_COMMA)
                    line_phase = csvrph_pkg::PH_ERROR;
            csvrph_pkg::PH_ACCEPT:
            begin
            end
            default:
                line_phase = csvrph_pkg::PH_ERROR;
        endcase
        if (last)
        begin
            rec = '0;
            if (line_phase == csvrph_pkg::PH_ACCEPT)
            begin
                rec.rank        = rank_acc;
                rec.population  = pop_acc;
                rec.hash_length = name_len;
                rec.hash_sum    = name_sum;
                if (name_seen >= 2'd2)
                    rec.hash_product = 9'((int'(first_b) * int'(second_b)) % BUCKETS);
                else if (name_seen == 2'd1)
                    rec.hash_product = 9'(int'(first_b) % BUCKETS);
            end
            else
                rec.status = 1'b1;
            pending_records.push_back(rec);
            clear_line_state();
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.data  <= '{in_byte: b, line_end: last};
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        parse_text_byte(b, last);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_word(line_bytes[i], i == line_bytes.size() - 1);
        random_words += line_bytes.size();
        line_bytes.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_line();
    endtask

    task automatic build_record_line(input int name_size);
        int         n;
        logic [7:0] b;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
        repeat (n) line_bytes.push_back(rand_digit());
        line_bytes.push_back(csvrph_pkg::CH_COMMA);
        line_bytes.push_back(csvrph_pkg::CH_QUOTE);
        n = (name_size < 0) ? $urandom_range(0, 6) : name_size;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == csvrph_pkg::CH_QUOTE)
                b = csvrph_pkg::CH_COMMA;
            line_bytes.push_back(b);
        end
        line_bytes.push_back(csvrph_pkg::CH_QUOTE);
        line_bytes.push_back(csvrph_pkg::CH_COMMA);
        if ($urandom_range(0, 2) == 0)
            line_bytes.push_back(csvrph_pkg::CH_LPAREN);
        else
        begin
            line_bytes.push_back(csvrph_pkg::CH_QUOTE);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
            repeat (n)
            begin
                line_bytes.push_back(rand_digit());
                if ($urandom_range(0, 3) == 0)
                    line_bytes.push_back(csvrph_pkg::CH_COMMA);
            end
            line_bytes.push_back(csvrph_pkg::CH_QUOTE);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_basic_records();
        send_text("0,\"\",\"\"");
        push_text("99999999999,\"");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        push_text("\",(xyz");
        send_line();
        send_text("7,\"A\",\"2,147,483,648\"");
    endtask

    task automatic test_malformed_lines();
        send_text("\n");
        send_text("5,\"ab");
        send_text("3,x\"q\",(");
        send_text("4,\"ab\",\"1a\"");
    endtask

    task automatic test_random_lines();
        int mode;
        int n;
        while (random_words < RANDOM_WORDS)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 7)
                build_record_line(-1);
            else if (mode == 7)
            begin
                build_record_line(-1);
                n = $urandom_range(1, line_bytes.size() - 1);
                while (line_bytes.size() > n)
                    void'(line_bytes.pop_back());
            end
            else if (mode == 8)
            begin
                build_record_line(-1);
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else
                repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            send_line();
        end
    endtask

    task automatic test_long_name();
        build_record_line(401);
        send_line();
    endtask

    task automatic test_unstalled_stream();
        idle_en = 1'b0;
        repeat (6)
        begin
            build_record_line(-1);
            send_line();
        end
    endtask

    task automatic check_record(input csvrph_pkg::out_word_t got);
        csvrph_pkg::out_word_t want;
        if (pending_records.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected record word: status=%0d rank=%0d pop=%0d",
                         got.status, got.rank, got.population);
        end
        else
        begin
            want = pending_records.pop_front();
            if (got.status !== want.status || got.rank !== want.rank ||
                got.population !== want.population || got.hash_length !== want.hash_length ||
                got.hash_sum !== want.hash_sum || got.hash_product !== want.hash_product)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("expected: st=%0d rank=%0d pop=%0d len=%0d sum=%0d prod=%0d",
                             want.status, want.rank, want.population,
                             want.hash_length, want.hash_sum, want.hash_product);
                    $display("actual:   st=%0d rank=%0d pop=%0d len=%0d sum=%0d prod=%0d",
                             got.status, got.rank, got.population,
                             got.hash_length, got.hash_sum, got.hash_product);
                end
            end
        end
    endtask

    initial
    begin
        record_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && record_if.valid && record_if.ready)
                check_record(record_if.data);
            if (!idle_en)
            begin
                stall_left = 0;
                record_if.ready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    record_if.ready <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15);
                record_if.ready <= 1'b0;
            end
            else
                record_if.ready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.data  <= '0;
        clear_line_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_records();
        test_malformed_lines();
        random_words = 0;
        test_random_lines();
        test_long_name();
        test_unstalled_stream();
        text_if.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/csvrph_pkg.sv
rtl/core/csvrph_if.sv
rtl/core/csv_record_parse_and_hash_top.sv
tb/tb_top.sv
